// ===== src/pixel_temporal_echo_filter_core_assert.svh =====
// Assertion macros for the temporal echo filter checker.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef PIXEL_TEMPORAL_ECHO_FILTER_CORE_ASSERT_SVH
`define PIXEL_TEMPORAL_ECHO_FILTER_CORE_ASSERT_SVH

// same-cycle implication, skipped while reset is asserted
`define PTEF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, skipped while reset is asserted
`define PTEF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ptef_pkg.sv =====
// Shared types and constants of the temporal echo filter.
// No dependencies; used by the core, the reciprocal unit and the checker.
package ptef_pkg;

	typedef struct packed {
		logic [15:0] pixel_index;
		logic [7:0]  y_in;
		logic [7:0]  u_in;
		logic [7:0]  v_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] y_out;
		logic [7:0] u_out;
		logic [7:0] v_out;
	} pix_out_t;

	typedef enum logic [0:0] {
		REG_INTENSITY = 1'b0,
		REG_DECAY     = 1'b1
	} reg_idx_t;

	localparam logic [7:0]  INTENSITY_RESET = 8'd255;
	localparam logic [8:0]  DECAY_RESET     = 9'd16;
	localparam logic [8:0]  DECAY_MAX       = 9'd256;

	localparam int LACC_W = 16;
	localparam int CACC_W = 17;
	localparam int ACC_W  = LACC_W + 2 * CACC_W;

	// reciprocal of the decay, 2^32 scaled
	localparam int RECIP_W = 32;

	// x / 255 as (x * 0x8081) >> 23, exact for x below 2^15
	localparam logic [15:0] RECIP255      = 16'h8081;
	localparam int          DIV255_SHIFT  = 23;

endpackage

// ===== src/ptef_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ptef_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/ptef_recip.sv =====
// Bit-serial reciprocal of the decay: recip = floor((2^32 - 1) / d) + 1.
// Depends on ptef_pkg for the reciprocal width.
module ptef_recip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [8:0]                   divisor,
	output logic                         busy,
	output logic [ptef_pkg::RECIP_W-1:0] recip
);

	localparam int CNT_W = $clog2(ptef_pkg::RECIP_W + 1);

	logic [CNT_W-1:0]             cnt_q;
	logic [8:0]                   rem_q;
	logic [ptef_pkg::RECIP_W-1:0] quo_q;
	logic [ptef_pkg::RECIP_W-1:0] recip_q;
	logic [9:0]                   trial;
	logic                         fits;
	logic [9:0]                   rem_next;

	// dividend is all ones, so every step shifts in a one
	assign trial    = {rem_q, 1'b1};
	assign fits     = (trial >= {1'b0, divisor});
	assign rem_next = fits ? (trial - {1'b0, divisor}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(ptef_pkg::RECIP_W);
			rem_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ptef_pkg::RECIP_W);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			rem_q <= rem_next[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (!start && cnt_q != '0) begin
			quo_q <= {quo_q[ptef_pkg::RECIP_W-2:0], fits};
			if (cnt_q == CNT_W'(1)) begin
				recip_q <= {quo_q[ptef_pkg::RECIP_W-2:0], fits} + ptef_pkg::RECIP_W'(1);
			end
		end
	end

	assign busy  = (cnt_q != '0);
	assign recip = recip_q;

endmodule

// ===== src/pixel_temporal_echo_filter_core.sv =====
// Temporal echo filter core: per-pixel recursive averaging of YUV samples.
// Depends on ptef_pkg, ptef_ram and ptef_recip.
//
// Usage:
//   Input channel (in_valid / in_stall / in_pixel) carries one pixel and its
//   frame position per transfer; output channel (out_valid / out_stall /
//   out_pixel) returns one filtered pixel per input, in order.
//   intensity (offset 0x0) and decay (offset 0x4) are written over the APB
//   port while the core is idle.
// Throughput: one pixel per clock while in_stall is low. A pixel whose
//   position matches one still in the four compute stages waits until that
//   one has written its accumulator.
// Reset: the accumulator RAM is swept to zero, one entry per cycle, over
//   min(FRAME_PIXELS, 65536) entries; in parallel the decay reciprocal is
//   computed serially. in_stall stays high until both finish.
//   Each decay write restarts the reciprocal with in_stall high.
// Output stall: a held result freezes the whole pipeline and raises in_stall;
//   nothing is dropped or repeated.
// Pipeline: accept (RAM read, gain products) -> s1 (gain divide, acc * (d-1))
//   -> s2 (add, magnitude) -> s3 (reciprocal multiply) -> s4 (write back,
//   round, clamp) -> output register.
module pixel_temporal_echo_filter_core #(
	parameter int FRAME_PIXELS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	// pixel input
	input  logic               in_valid,
	output logic               in_stall,
	input  ptef_pkg::pix_in_t  in_pixel,
	// pixel output
	output logic               out_valid,
	input  logic               out_stall,
	output ptef_pkg::pix_out_t out_pixel,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int STORE_DEPTH = (FRAME_PIXELS < 65536) ? FRAME_PIXELS : 65536;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LW          = ptef_pkg::LACC_W;
	localparam int CW          = ptef_pkg::CACC_W;

	// ------------------------------------------------------------------
	// Arithmetic helpers
	// ------------------------------------------------------------------

	// symmetric rounding of p / 255: (|p| + 127) / 255, sign kept apart
	function automatic logic [7:0] chroma_gain(input logic signed [17:0] p);
		logic [17:0] mag;
		logic [14:0] biased;
		logic [30:0] prod;
		mag    = p[17] ? 18'(-p) : 18'(p);
		biased = mag[14:0] + 15'd127;
		prod   = 31'(biased) * 31'(ptef_pkg::RECIP255);
		return 8'(prod >> ptef_pkg::DIV255_SHIFT);
	endfunction

	// truncating divide by the decay through its reciprocal
	function automatic logic [23:0] div_decay(input logic [23:0] mag,
		input logic [ptef_pkg::RECIP_W-1:0] rcp, input logic one);
		logic [55:0] prod;
		prod = 56'(mag) * 56'(rcp);
		return one ? mag : prod[55:32];
	endfunction

	// round to nearest, re-center at 128, clamp to 0..255
	function automatic logic [7:0] chroma_out(input logic signed [CW-1:0] acc);
		logic signed [17:0] t;
		logic signed [9:0]  r;
		t = 18'(acc) + 18'sd128;
		r = $signed(t[17:8]) + 10'sd128;
		if (r[9]) begin
			return 8'd0;
		end else if (r[8]) begin
			return 8'd255;
		end else begin
			return r[7:0];
		end
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic       cfg_wr;
	logic [7:0] intensity_q;
	logic [8:0] decay_q;
	logic [8:0] d_eff;
	logic [7:0] dm;
	logic       d_one;

	// a transfer completes on the access cycle; pready is tied high
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= ptef_pkg::INTENSITY_RESET;
			decay_q     <= ptef_pkg::DECAY_RESET;
		end else if (cfg_wr) begin
			case (ptef_pkg::reg_idx_t'(paddr[2]))
				ptef_pkg::REG_INTENSITY: intensity_q <= pwdata[7:0];
				ptef_pkg::REG_DECAY:     decay_q     <= pwdata[8:0];
				default:                 intensity_q <= intensity_q;
			endcase
		end
	end

	always_comb begin
		case (ptef_pkg::reg_idx_t'(paddr[2]))
			ptef_pkg::REG_INTENSITY: prdata = {24'd0, intensity_q};
			ptef_pkg::REG_DECAY:     prdata = {23'd0, decay_q};
			default:                 prdata = '0;
		endcase
	end

	// clamp decay to 1..256
	assign d_eff = (decay_q == 9'd0) ? 9'd1 :
		(decay_q > ptef_pkg::DECAY_MAX) ? ptef_pkg::DECAY_MAX : decay_q;
	assign dm    = 8'(d_eff - 9'd1);
	assign d_one = (d_eff == 9'd1);

	// ------------------------------------------------------------------
	// Reciprocal of the decay
	// ------------------------------------------------------------------
	logic                         recip_start;
	logic                         recip_busy;
	logic [ptef_pkg::RECIP_W-1:0] recip;

	assign recip_start = cfg_wr &&
		(ptef_pkg::reg_idx_t'(paddr[2]) == ptef_pkg::REG_DECAY);

	ptef_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recip_start),
		.divisor (d_eff),
		.busy    (recip_busy),
		.recip   (recip)
	);

	// ------------------------------------------------------------------
	// Accumulator clearing sweep after reset
	// ------------------------------------------------------------------
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic adv;
	logic accept;
	logic hazard;
	logic upd0;

	logic v_s1, v_s2, v_s3, v_s4;
	logic upd_s1, upd_s2, upd_s3, upd_s4;
	ptef_pkg::pix_in_t in_s1, in_s2, in_s3, in_s4;

	logic               out_valid_q;
	ptef_pkg::pix_out_t out_q;

	// advance everything unless a finished result is held back
	assign adv = !(out_valid_q && out_stall);

	// hold a pixel whose entry is still being updated further down
	assign hazard =
		(v_s1 && upd_s1 && in_s1.pixel_index == in_pixel.pixel_index) ||
		(v_s2 && upd_s2 && in_s2.pixel_index == in_pixel.pixel_index) ||
		(v_s3 && upd_s3 && in_s3.pixel_index == in_pixel.pixel_index) ||
		(v_s4 && upd_s4 && in_s4.pixel_index == in_pixel.pixel_index);

	assign in_stall = !adv || clr_q || recip_busy || hazard;
	assign accept   = in_valid && !in_stall;

	// pixels outside the store, or at zero gain, pass straight through
	assign upd0 = (intensity_q != 8'd0) &&
		({1'b0, in_pixel.pixel_index} < 17'(STORE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Accept stage: gain products
	// ------------------------------------------------------------------
	logic [15:0]        py0;
	logic signed [17:0] pu0, pv0;

	assign py0 = {8'd0, in_pixel.y_in} * {8'd0, intensity_q};
	assign pu0 = ($signed({1'b0, in_pixel.u_in}) - 9'sd128) * $signed({1'b0, intensity_q});
	assign pv0 = ($signed({1'b0, in_pixel.v_in}) - 9'sd128) * $signed({1'b0, intensity_q});

	logic [15:0]        py_s1;
	logic signed [17:0] pu_s1, pv_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			upd_s1 <= upd0;
			in_s1  <= in_pixel;
			py_s1  <= py0;
			pu_s1  <= pu0;
			pv_s1  <= pv0;
		end
	end

	// ------------------------------------------------------------------
	// Accumulator RAM: read at accept, written back from s4
	// ------------------------------------------------------------------
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [ptef_pkg::ACC_W-1:0] ram_wdata;
	logic [ptef_pkg::ACC_W-1:0] ram_rdata;
	logic [ptef_pkg::ACC_W-1:0] acc_new_s4;

	assign ram_we    = clr_q || (adv && v_s4 && upd_s4);
	assign ram_waddr = clr_q ? clr_cnt_q : in_s4.pixel_index[AW-1:0];
	assign ram_wdata = clr_q ? '0 : acc_new_s4;

	ptef_ram #(
		.WIDTH (ptef_pkg::ACC_W),
		.DEPTH (STORE_DEPTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_pixel.pixel_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: finish gains, weight old accumulators by (decay - 1)
	// ------------------------------------------------------------------
	logic [LW-1:0]        lacc1;
	logic signed [CW-1:0] uacc1, vacc1;
	logic [16:0]          fy_sum1;
	logic [23:0]          prodl1;
	logic signed [25:0]   produ1, prodv1;

	assign lacc1 = ram_rdata[ptef_pkg::ACC_W-1 -: LW];
	assign uacc1 = $signed(ram_rdata[2*CW-1 -: CW]);
	assign vacc1 = $signed(ram_rdata[CW-1:0]);

	// shift-based divide by 255 of the luma product
	assign fy_sum1 = {1'b0, py_s1} + 17'd1 + {9'd0, py_s1[15:8]};

	assign prodl1 = {8'd0, lacc1} * {16'd0, dm};
	assign produ1 = uacc1 * $signed({1'b0, dm});
	assign prodv1 = vacc1 * $signed({1'b0, dm});

	logic [23:0]        prodl_s2;
	logic signed [25:0] produ_s2, prodv_s2;
	logic [7:0]         fy_s2, gu_s2, gv_s2;
	logic               gu_neg_s2, gv_neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			upd_s2    <= upd_s1;
			in_s2     <= in_s1;
			prodl_s2  <= prodl1;
			produ_s2  <= produ1;
			prodv_s2  <= prodv1;
			fy_s2     <= fy_sum1[15:8];
			gu_s2     <= chroma_gain(pu_s1);
			gv_s2     <= chroma_gain(pv_s1);
			gu_neg_s2 <= pu_s1[17];
			gv_neg_s2 <= pv_s1[17];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: add the new sample, split sign and magnitude
	// ------------------------------------------------------------------
	logic [23:0]        numl2;
	logic signed [25:0] fu2, fv2, nu2, nv2;

	assign numl2 = prodl_s2 + {8'd0, fy_s2, 8'd0};
	assign fu2   = $signed({10'd0, gu_s2, 8'd0});
	assign fv2   = $signed({10'd0, gv_s2, 8'd0});
	assign nu2   = gu_neg_s2 ? (produ_s2 - fu2) : (produ_s2 + fu2);
	assign nv2   = gv_neg_s2 ? (prodv_s2 - fv2) : (prodv_s2 + fv2);

	logic [23:0] numl_s3, magu_s3, magv_s3;
	logic        negu_s3, negv_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			upd_s3  <= upd_s2;
			in_s3   <= in_s2;
			numl_s3 <= numl2;
			magu_s3 <= nu2[25] ? 24'(-nu2) : nu2[23:0];
			magv_s3 <= nv2[25] ? 24'(-nv2) : nv2[23:0];
			negu_s3 <= nu2[25];
			negv_s3 <= nv2[25];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: divide by decay (truncating toward zero)
	// ------------------------------------------------------------------
	logic [23:0] ql3, qu3, qv3;

	assign ql3 = div_decay(numl_s3, recip, d_one);
	assign qu3 = div_decay(magu_s3, recip, d_one);
	assign qv3 = div_decay(magv_s3, recip, d_one);

	logic [15:0] ql_s4, qu_s4, qv_s4;
	logic        negu_s4, negv_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			upd_s4  <= upd_s3;
			in_s4   <= in_s3;
			ql_s4   <= ql3[15:0];
			qu_s4   <= qu3[15:0];
			qv_s4   <= qv3[15:0];
			negu_s4 <= negu_s3;
			negv_s4 <= negv_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: new accumulators, write back, round and clamp
	// ------------------------------------------------------------------
	logic signed [CW-1:0] accu4, accv4;
	logic [16:0]          ly_round4;
	ptef_pkg::pix_out_t   res4;

	assign accu4 = negu_s4 ? -$signed({1'b0, qu_s4}) : $signed({1'b0, qu_s4});
	assign accv4 = negv_s4 ? -$signed({1'b0, qv_s4}) : $signed({1'b0, qv_s4});

	assign acc_new_s4 = {ql_s4, accu4, accv4};

	assign ly_round4 = {1'b0, ql_s4} + 17'd128;

	always_comb begin
		if (upd_s4) begin
			res4.y_out = ly_round4[15:8];
			res4.u_out = chroma_out(accu4);
			res4.v_out = chroma_out(accv4);
		end else begin
			res4.y_out = in_s4.y_in;
			res4.u_out = in_s4.u_in;
			res4.v_out = in_s4.v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_q;

endmodule

// ===== src/ptef_chk.sv =====
// Port-level checker for the temporal echo filter core, bound to the top.
// Depends on ptef_pkg and pixel_temporal_echo_filter_core_assert.svh.
`include "pixel_temporal_echo_filter_core_assert.svh"

module ptef_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input ptef_pkg::pix_out_t out_pixel,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr
);

	logic decay_wr;

	assign decay_wr = psel && penable && pwrite &&
		(ptef_pkg::reg_idx_t'(paddr[2]) == ptef_pkg::REG_DECAY);

	// a held result freezes the pipeline, so no new transfer may enter
	`PTEF_ASSERT_NOW(a_stall_backpressure, out_valid && out_stall, in_stall, "input open")

	// a held result keeps its value
	`PTEF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_pixel), "held out")

	// a decay write restarts the reciprocal, which blocks input
	`PTEF_ASSERT_NEXT(a_decay_blocks, decay_wr, in_stall, "input open on decay update")

	// the clearing sweep blocks input right after reset
	`PTEF_ASSERT_NOW(a_reset_blocks, !$past(arst_n), in_stall, "input open after reset")

endmodule

bind pixel_temporal_echo_filter_core ptef_chk u_ptef_chk (.*);
